// ===== hdl/ecsd_pkg.sv =====
// ----------------------------------------------------------------------------
// ecsd_pkg
// Shared types, constants and lookup functions for the encoder counter with
// two-digit seven-segment display driver.
// ----------------------------------------------------------------------------
package ecsd_pkg;

    localparam int COUNT_W    = 7;
    localparam int SEG_W      = 7;
    localparam int POS_W      = 4;
    localparam int WORM_STEPS = 12;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd99;

    typedef logic [1:0] t_op;
    localparam t_op OP_STEP  = 2'd0;
    localparam t_op OP_PRESS = 2'd1;
    localparam t_op OP_TICK  = 2'd2;

    typedef struct packed {
        t_op  op;
        logic dir_down;
    } t_event;

    typedef struct packed {
        logic               worm_active;
        logic [COUNT_W-1:0] count_value;
        logic               tens_enable;
        logic               units_enable;
        logic [SEG_W-1:0]   segments_lit;
    } t_result;

    function automatic logic [SEG_W-1:0] digit_mask(input logic [3:0] d);
        logic [SEG_W-1:0] m;
        case (d)
            4'd0:    m = 7'h3F;
            4'd1:    m = 7'h06;
            4'd2:    m = 7'h5B;
            4'd3:    m = 7'h4F;
            4'd4:    m = 7'h66;
            4'd5:    m = 7'h6D;
            4'd6:    m = 7'h7D;
            4'd7:    m = 7'h07;
            4'd8:    m = 7'h7F;
            4'd9:    m = 7'h6F;
            default: m = 7'h3F; // digits above nine show zero
        endcase
        return m;
    endfunction

    function automatic logic [SEG_W-1:0] worm_seg(input logic [POS_W-1:0] p);
        logic [SEG_W-1:0] m;
        case (p)
            4'd2, 4'd6:         m = 7'h20;
            4'd3, 4'd5:         m = 7'h10;
            4'd4, 4'd9:         m = 7'h08;
            4'd7, 4'd11:        m = 7'h02;
            4'd8, 4'd10:        m = 7'h04;
            default:            m = 7'h01;
        endcase
        return m;
    endfunction

    function automatic logic worm_tens(input logic [POS_W-1:0] p);
        logic t;
        case (p)
            4'd1, 4'd2, 4'd3, 4'd4, 4'd7, 4'd8: t = 1'b1;
            default:                            t = 1'b0;
        endcase
        return t;
    endfunction

endpackage

// ===== hdl/ecsd_in_stage.sv =====
// ----------------------------------------------------------------------------
// ecsd_in_stage
// Input register for event beats; releases a beat when the core advances.
// ----------------------------------------------------------------------------
module ecsd_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ecsd_pkg::t_event i_event,
    input  logic            i_advance,
    output logic            o_valid,
    output ecsd_pkg::t_event o_event
);
    import ecsd_pkg::*;

    logic   r_valid;
    t_event r_event;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_event = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_event <= i_event;
        end
    end

endmodule

// ===== hdl/ecsd_core.sv =====
// ----------------------------------------------------------------------------
// ecsd_core
// Counter, mode, worm position and display state with their update logic.
// ----------------------------------------------------------------------------
module ecsd_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_limit_we,
    input  logic [ecsd_pkg::COUNT_W-1:0] i_limit,
    input  logic                      i_fire,
    input  ecsd_pkg::t_event          i_event,
    output ecsd_pkg::t_result         o_result
);
    import ecsd_pkg::*;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WORM_STEPS - 1);

    logic [COUNT_W-1:0] r_limit;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_worm, n_worm;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_tens, n_tens;
    logic [SEG_W-1:0]   r_seg, n_seg;

    logic [14:0]        tens_prod;
    logic [3:0]         tens_digit;
    logic [3:0]         units_digit;

    // divide by ten through multiply by 205 and shift, exact for 7-bit values
    assign tens_prod   = 15'(r_count) * 15'd205;
    assign tens_digit  = tens_prod[14:11];
    assign units_digit = 4'(r_count - 7'(tens_digit) * 7'd10);

    always_comb begin
        n_count = r_count;
        n_worm  = r_worm;
        n_pos   = r_pos;
        n_tens  = r_tens;
        n_seg   = r_seg;
        if (i_event.op == OP_PRESS) begin
            n_worm = !r_worm;
        end else if (!r_worm) begin
            if (i_event.op == OP_STEP) begin
                if (!i_event.dir_down) begin
                    if (r_count < r_limit) n_count = r_count + 7'd1;
                end else if (r_count != '0) begin
                    n_count = r_count - 7'd1;
                end
            end else if (i_event.op == OP_TICK) begin
                n_tens = !r_tens;
                n_seg  = n_tens ? digit_mask(tens_digit) : digit_mask(units_digit);
            end
        end else if (i_event.op == OP_STEP) begin
            if (!i_event.dir_down) begin
                n_pos = (r_pos >= POS_LAST) ? '0 : r_pos + 1'b1;
            end else begin
                n_pos = (r_pos == '0 || r_pos > POS_LAST) ? POS_LAST : r_pos - 1'b1;
            end
        end
        // worm mode re-drives segment and digit from the ring position
        if (n_worm) begin
            n_seg  = worm_seg(n_pos);
            n_tens = worm_tens(n_pos);
        end
    end

    assign o_result.segments_lit = n_seg;
    assign o_result.units_enable = !n_tens;
    assign o_result.tens_enable  = n_tens;
    assign o_result.count_value  = n_count;
    assign o_result.worm_active  = n_worm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_limit_we) begin
            r_limit <= i_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_worm  <= 1'b0;
            r_pos   <= '0;
            r_tens  <= 1'b0;
            r_seg   <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
            r_worm  <= n_worm;
            r_pos   <= n_pos;
            r_tens  <= n_tens;
            r_seg   <= n_seg;
        end
    end

    a_press_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_event.op == OP_PRESS |=> r_worm != $past(r_worm))
        else $error("press did not toggle mode");

    a_count_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire || r_worm || i_event.op != OP_STEP |=> $stable(r_count))
        else $error("count moved without a counter step");

    a_worm_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && n_worm |=> r_seg == worm_seg(r_pos) && r_tens == worm_tens(r_pos))
        else $error("worm drive does not match position");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_pos) && $stable(r_seg) && $stable(r_worm))
        else $error("state changed without a beat");

endmodule

// ===== hdl/ecsd_out_stage.sv =====
// ----------------------------------------------------------------------------
// ecsd_out_stage
// Result register that decouples the core from output backpressure.
// ----------------------------------------------------------------------------
module ecsd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ecsd_pkg::t_result i_result,
    output logic              o_advance,
    output logic              o_valid,
    input  logic              i_ready,
    output ecsd_pkg::t_result o_result
);
    import ecsd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_advance = i_valid && (!r_valid || i_ready);
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== hdl/encoder_counter_seven_segment_driver.sv =====
// ----------------------------------------------------------------------------
// encoder_counter_seven_segment_driver
// Encoder counter / worm animation with two-digit multiplexed display drive.
// ----------------------------------------------------------------------------
// path: input beat held in the input register, result beat held in the result register
// throughput: 1 beat per cycle while m_axis_tready allows; state update is a single pass between the registers
// reset: synchronous active low; counter mode, count 0, position 0, units digit,
// segments dark, count limit 99
module encoder_counter_seven_segment_driver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_count_limit_we,
    input  logic [6:0]  i_count_limit,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] direction_level
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [6:0] segments_lit, [7] units_enable,
                                        // [8] tens_enable, [15:9] count_value,
                                        // [16] worm_active
);
    import ecsd_pkg::*;

    t_event  in_event;
    t_event  stage_event;
    logic    stage_valid;
    logic    advance;
    t_result core_result;
    t_result out_result;

    assign in_event.op       = s_axis_tuser;
    assign in_event.dir_down = s_axis_tdata[0];

    ecsd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_event   (in_event),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_event   (stage_event)
    );

    ecsd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_limit_we (i_count_limit_we),
        .i_limit    (i_count_limit),
        .i_fire     (advance),
        .i_event    (stage_event),
        .o_result   (core_result)
    );

    ecsd_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stage_valid),
        .i_result  (core_result),
        .o_advance (advance),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (out_result)
    );

    assign m_axis_tdata = {7'd0, out_result};

endmodule
